// File: design/tmbc_pkg.sv
// Shared types, widths and codes for the tile map box collision resolver.
// Used by every module of the block but the port checks; depends on nothing.

package tmbc_pkg;

  // Default map store geometry.
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Field widths.
  localparam int TILE_W  = 8;
  localparam int MAP_W   = 7;
  localparam int COORD_W = 20;
  localparam int OFF_W   = 16;
  localparam int SIZE_W  = 8;
  localparam int IDX_W   = 12;

  // Box edge values before the division, and the division result.
  localparam int NUM_W = 22;
  localparam int MAG_W = NUM_W - 4;
  localparam int QUO_W = MAG_W + 1;

  // Number of divider lanes: first and last tile of two boxes on two axes.
  localparam int LANES = 8;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the configuration registers.
  localparam logic [TILE_W-1:0] RST_TILE_WIDTH  = 8'd16;
  localparam logic [TILE_W-1:0] RST_TILE_HEIGHT = 8'd16;
  localparam logic [MAP_W-1:0]  RST_MAP_COLS    = 7'd64;
  localparam logic [MAP_W-1:0]  RST_MAP_ROWS    = 7'd64;

  // Item kinds.
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  typedef enum logic [1:0] {
    CFG_TILE_WIDTH  = 2'd0,
    CFG_TILE_HEIGHT = 2'd1,
    CFG_MAP_COLS    = 2'd2,
    CFG_MAP_ROWS    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUT_FREE = 2'd0,
    OUT_Y    = 2'd1,
    OUT_X    = 2'd2,
    OUT_BOTH = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_START,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_CLASS,
    B_READ,
    B_CHECK
  } back_state_e;

  // Which box the back part is testing.
  typedef enum logic [1:0] {
    BOX_CUR,
    BOX_PREV_Y,
    BOX_PREV_X
  } box_sel_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [QUO_W-1:0]   quo_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile_width;
    logic [TILE_W-1:0] tile_height;
    logic [MAP_W-1:0]  map_cols;
    logic [MAP_W-1:0]  map_rows;
  } cfg_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    logic             is_write;
    logic [IDX_W-1:0] tile_index;
    logic             tile_blocked;
    coord_t           pos_x;
    coord_t           pos_y;
    coord_t           prev_x;
    coord_t           prev_y;
    quo_t             cur_left;
    quo_t             cur_right;
    quo_t             prev_left;
    quo_t             prev_right;
    quo_t             cur_top;
    quo_t             cur_bottom;
    quo_t             prev_top;
    quo_t             prev_bottom;
  } entry_t;

endpackage

// File: design/tmbc_div.sv
// Radix-2 restoring divider lane: signed box edge over tile size, truncating
// toward zero. Depends on tmbc_pkg.

module tmbc_div import tmbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [TILE_W-1:0]       den_i,
  output quo_t                    quo_o,
  output logic                    done_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic              run_q, run_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [TILE_W-1:0] rem_q, rem_d;
  logic [TILE_W-1:0] den_q, den_d;
  logic              neg_q, neg_d;
  logic [NUM_W-1:0]  abs_num;
  logic [TILE_W:0]   trial;
  logic              ge;

  always_comb begin
    abs_num = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    trial   = {rem_q, mag_q[MAG_W-1]};
    ge      = (trial >= {1'b0, den_q});
    run_d   = run_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      mag_d = abs_num[NUM_W-1:4];
      rem_d = '0;
      den_d = den_i;
      neg_d = num_i[NUM_W-1];
    end else if (run_q) begin
      mag_d = {mag_q[MAG_W-2:0], ge};
      rem_d = ge ? TILE_W'(trial - {1'b0, den_q}) : TILE_W'(trial);
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MAG_W - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quo_o  = neg_q ? -quo_t'({1'b0, mag_q}) : quo_t'({1'b0, mag_q});
  assign done_o = !run_q;

endmodule

// File: design/tmbc_front.sv
// Front part: takes items, forms box edges and divides them into tile
// numbers on eight divider lanes. Depends on tmbc_pkg and tmbc_div.

module tmbc_front import tmbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                ready_o,
  input  logic                action_i,
  input  logic [IDX_W-1:0]    tile_index_i,
  input  logic                tile_blocked_i,
  input  coord_t              pos_x_i,
  input  coord_t              pos_y_i,
  input  coord_t              prev_x_i,
  input  coord_t              prev_y_i,
  input  logic [SIZE_W-1:0]   box_width_i,
  input  logic [SIZE_W-1:0]   box_height_i,
  input  logic signed [OFF_W-1:0] offset_x_i,
  input  logic signed [OFF_W-1:0] offset_y_i,
  input  cfg_t                cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output entry_t              entry_o
);

  front_state_e state_q, state_d;

  logic                    is_write_q;
  logic [IDX_W-1:0]        tile_index_q;
  logic                    tile_blocked_q;
  coord_t                  px_q, py_q, qx_q, qy_q;
  logic [SIZE_W-1:0]       w_q, h_q;
  logic signed [OFF_W-1:0] ox_q, oy_q;
  logic signed [NUM_W-1:0] num_q [LANES];
  logic signed [NUM_W-1:0] num_d [LANES];
  logic signed [NUM_W-1:0] hx, hy, phx, phy, span_w, span_h;
  logic [TILE_W-1:0]       tw_eff, th_eff;
  logic                    accept, div_start;
  quo_t                    quo [LANES];
  logic [LANES-1:0]        lane_done;

  assign accept = start_i && (state_q == F_IDLE);
  assign tw_eff = (cfg_i.tile_width == '0) ? TILE_W'(1) : cfg_i.tile_width;
  assign th_eff = (cfg_i.tile_height == '0) ? TILE_W'(1) : cfg_i.tile_height;

  // Box corner is centre minus half the size plus the offset; the last pixel
  // of the box sits 16 * (size - 1) further on.
  always_comb begin
    hx     = NUM_W'(px_q) - NUM_W'($signed({1'b0, w_q, 3'b000})) + NUM_W'(ox_q);
    phx    = NUM_W'(qx_q) - NUM_W'($signed({1'b0, w_q, 3'b000})) + NUM_W'(ox_q);
    hy     = NUM_W'(py_q) - NUM_W'($signed({1'b0, h_q, 3'b000})) + NUM_W'(oy_q);
    phy    = NUM_W'(qy_q) - NUM_W'($signed({1'b0, h_q, 3'b000})) + NUM_W'(oy_q);
    span_w = NUM_W'($signed({1'b0, w_q, 4'b0000})) - NUM_W'(16);
    span_h = NUM_W'($signed({1'b0, h_q, 4'b0000})) - NUM_W'(16);
    num_d[0] = hx;
    num_d[1] = hx + span_w;
    num_d[2] = phx;
    num_d[3] = phx + span_w;
    num_d[4] = hy;
    num_d[5] = hy + span_h;
    num_d[6] = phy;
    num_d[7] = phy + span_h;
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    push_o    = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          state_d = (action_i == ACT_WRITE) ? F_PUSH : F_PREP;
        end
      end
      F_PREP: begin
        state_d = F_START;
      end
      F_START: begin
        div_start = 1'b1;
        state_d   = F_DIV;
      end
      F_DIV: begin
        if (&lane_done) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_write_q     <= (action_i == ACT_WRITE);
      tile_index_q   <= tile_index_i;
      tile_blocked_q <= tile_blocked_i;
      px_q           <= pos_x_i;
      py_q           <= pos_y_i;
      qx_q           <= prev_x_i;
      qy_q           <= prev_y_i;
      w_q            <= box_width_i;
      h_q            <= box_height_i;
      ox_q           <= offset_x_i;
      oy_q           <= offset_y_i;
    end
    if (state_q == F_PREP) begin
      num_q <= num_d;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tmbc_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(div_start),
      .num_i  (num_q[g]),
      .den_i  ((g < LANES / 2) ? tw_eff : th_eff),
      .quo_o  (quo[g]),
      .done_o (lane_done[g])
    );
  end

  always_comb begin
    entry_o.is_write     = is_write_q;
    entry_o.tile_index   = tile_index_q;
    entry_o.tile_blocked = tile_blocked_q;
    entry_o.pos_x        = px_q;
    entry_o.pos_y        = py_q;
    entry_o.prev_x       = qx_q;
    entry_o.prev_y       = qy_q;
    entry_o.cur_left     = quo[0];
    entry_o.cur_right    = quo[1];
    entry_o.prev_left    = quo[2];
    entry_o.prev_right   = quo[3];
    entry_o.cur_top      = quo[4];
    entry_o.cur_bottom   = quo[5];
    entry_o.prev_top     = quo[6];
    entry_o.prev_bottom  = quo[7];
  end

  assign ready_o = (state_q == F_IDLE);

endmodule

// File: design/tmbc_fifo.sv
// Short queue of classified items between front and back.
// Depends on tmbc_pkg.

module tmbc_fifo import tmbc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_q];
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// File: design/tmbc_back.sv
// Back part: owns the blocked-tile store, applies tile writes and walks the
// tiles of up to three boxes per resolve. Depends on tmbc_pkg.

module tmbc_back import tmbc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     empty_i,
  input  entry_t   head_i,
  output logic     pop_o,
  output logic     clearing_o,
  output logic     done_o,
  output coord_t   new_x_o,
  output coord_t   new_y_o,
  output outcome_e outcome_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);

  logic blocked_q [DEPTH];

  back_state_e    state_q, state_d;
  box_sel_e       sel_q, sel_d;
  entry_t         ent_q, ent_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CLW-1:0] col_q, col_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           rd_q;
  logic           done_q, done_d;
  coord_t         new_x_q, new_x_d, new_y_q, new_y_d;
  outcome_e       outcome_q, outcome_d;

  logic           mem_we, mem_wdata;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [CCW-1:0] eff_cols;
  logic [RCW-1:0] eff_rows;
  quo_t           cols_s, rows_s;
  quo_t           bx_first, bx_last, by_first, by_last;
  logic           span_empty, outside;

  assign eff_cols = (32'(cfg_i.map_cols) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cfg_i.map_cols);
  assign eff_rows = (32'(cfg_i.map_rows) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg_i.map_rows);
  assign cols_s   = quo_t'(eff_cols);
  assign rows_s   = quo_t'(eff_rows);

  always_comb begin
    case (sel_q)
      BOX_PREV_Y: begin
        bx_first = ent_q.cur_left;
        bx_last  = ent_q.cur_right;
        by_first = ent_q.prev_top;
        by_last  = ent_q.prev_bottom;
      end
      BOX_PREV_X: begin
        bx_first = ent_q.prev_left;
        bx_last  = ent_q.prev_right;
        by_first = ent_q.cur_top;
        by_last  = ent_q.cur_bottom;
      end
      default: begin
        bx_first = ent_q.cur_left;
        bx_last  = ent_q.cur_right;
        by_first = ent_q.cur_top;
        by_last  = ent_q.cur_bottom;
      end
    endcase
    span_empty = (bx_last < bx_first) || (by_last < by_first);
    outside    = bx_first[QUO_W-1] || by_first[QUO_W-1] ||
                 (bx_last >= cols_s) || (by_last >= rows_s);
  end

  assign mem_raddr = AW'(AW'(row_q) * AW'(eff_cols) + AW'(col_q));

  always_comb begin
    logic     finish;
    logic     hit;
    logic     emit;
    outcome_e code;
    finish    = 1'b0;
    hit       = 1'b0;
    emit      = 1'b0;
    code      = OUT_FREE;
    state_d   = state_q;
    sel_d     = sel_q;
    ent_d     = ent_q;
    row_d     = row_q;
    col_d     = col_q;
    clr_d     = clr_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b0;
    done_d    = 1'b0;
    outcome_d = outcome_q;
    new_x_d   = new_x_q;
    new_y_d   = new_y_q;
    case (state_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = B_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.is_write) begin
            if (32'(head_i.tile_index) < DEPTH) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(head_i.tile_index);
              mem_wdata = head_i.tile_blocked;
            end
          end else begin
            ent_d   = head_i;
            sel_d   = BOX_CUR;
            state_d = B_CLASS;
          end
        end
      end
      B_CLASS: begin
        if (span_empty) begin
          finish = 1'b1;
        end else if (outside) begin
          finish = 1'b1;
          hit    = 1'b1;
        end else begin
          row_d   = by_first[RW-1:0];
          col_d   = bx_first[CLW-1:0];
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        if (rd_q) begin
          finish = 1'b1;
          hit    = 1'b1;
        end else if (col_q == bx_last[CLW-1:0]) begin
          if (row_q == by_last[RW-1:0]) begin
            finish = 1'b1;
          end else begin
            row_d   = row_q + RW'(1);
            col_d   = bx_first[CLW-1:0];
            state_d = B_READ;
          end
        end else begin
          col_d   = col_q + CLW'(1);
          state_d = B_READ;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    // Try the current box, then y reverted, then x reverted.
    if (finish) begin
      case (sel_q)
        BOX_CUR: begin
          if (hit) begin
            sel_d   = BOX_PREV_Y;
            state_d = B_CLASS;
          end else begin
            emit = 1'b1;
            code = OUT_FREE;
          end
        end
        BOX_PREV_Y: begin
          if (hit) begin
            sel_d   = BOX_PREV_X;
            state_d = B_CLASS;
          end else begin
            emit = 1'b1;
            code = OUT_Y;
          end
        end
        default: begin
          emit = 1'b1;
          code = hit ? OUT_BOTH : OUT_X;
        end
      endcase
    end

    if (emit) begin
      state_d   = B_IDLE;
      done_d    = 1'b1;
      outcome_d = code;
      new_x_d   = (code == OUT_X || code == OUT_BOTH) ? ent_q.prev_x : ent_q.pos_x;
      new_y_d   = (code == OUT_Y || code == OUT_BOTH) ? ent_q.prev_y : ent_q.pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q     <= sel_d;
    ent_q     <= ent_d;
    row_q     <= row_d;
    col_q     <= col_d;
    outcome_q <= outcome_d;
    new_x_q   <= new_x_d;
    new_y_q   <= new_y_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blocked_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= blocked_q[mem_raddr];
  end

  assign clearing_o = (state_q == B_CLEAR);
  assign done_o     = done_q;
  assign new_x_o    = new_x_q;
  assign new_y_o    = new_y_q;
  assign outcome_o  = outcome_q;

endmodule

// File: design/tile_map_box_collision_resolve.sv
// Top level of the tile map box collision resolver: configuration registers,
// front, queue and back. Depends on tmbc_pkg, tmbc_front, tmbc_fifo, tmbc_back.

// The block keeps a map of blocked tiles and resolves entity boxes against it.
// An item is a transfer on start_i while busy_o is low. A tile write (action 0)
// sets or clears one tile mark and returns nothing; a resolve (action 1) returns
// one result, shown for exactly one cycle with done_o high. The receiver cannot
// stall, so it must take every result in the cycle it appears. After reset the
// tile store is swept clear, one tile per clock, which keeps busy_o high until
// all MAX_ROWS * MAX_COLS tiles (4096 at the defaults) are clear; configuration
// writes are taken during that time. For a resolve the front part accepts the
// item, forms the box edges, loads the bit-serial dividers that turn edges into
// tile numbers, sees them finish and hands the item to the queue once it has
// room; a tile write is accepted and handed straight to the queue. A two-entry
// queue then lets the front take the next item while the back part works. The
// back part takes an item from the queue, tests up to three boxes per resolve
// and reads each tile that a box covers, in a read state and then a check state,
// since every read of the store is registered before it is examined; a box that
// leaves the map or covers no tile needs no reads. Small boxes over a few tiles
// therefore leave the front part setting the pace; only when the boxes tested
// for one resolve cover about ten tiles or more together does the back part
// become the limit. The user must write configuration only when the block is
// idle; the block itself does not enforce it.

module tile_map_box_collision_resolve import tmbc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [TILE_W-1:0]       cfg_data_i,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    action_i,
  input  logic [IDX_W-1:0]        tile_index_i,
  input  logic                    tile_blocked_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] prev_x_i,
  input  logic signed [COORD_W-1:0] prev_y_i,
  input  logic [SIZE_W-1:0]       box_width_i,
  input  logic [SIZE_W-1:0]       box_height_i,
  input  logic signed [OFF_W-1:0] offset_x_i,
  input  logic signed [OFF_W-1:0] offset_y_i,
  output logic                    done_o,
  output logic signed [COORD_W-1:0] new_x_o,
  output logic signed [COORD_W-1:0] new_y_o,
  output logic [1:0]              outcome_o
);

  cfg_t     cfg_q, cfg_d;
  logic     front_ready, clearing;
  logic     push, pop, full, empty;
  entry_t   push_entry, head_entry;
  outcome_e outcome;
  coord_t   new_x, new_y;

  // Configuration writes land in the register named by the index; the map
  // sizes keep their low seven bits.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TILE_WIDTH:  cfg_d.tile_width  = cfg_data_i;
        CFG_TILE_HEIGHT: cfg_d.tile_height = cfg_data_i;
        CFG_MAP_COLS:    cfg_d.map_cols    = cfg_data_i[MAP_W-1:0];
        CFG_MAP_ROWS:    cfg_d.map_rows    = cfg_data_i[MAP_W-1:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_width  <= RST_TILE_WIDTH;
      cfg_q.tile_height <= RST_TILE_HEIGHT;
      cfg_q.map_cols    <= RST_MAP_COLS;
      cfg_q.map_rows    <= RST_MAP_ROWS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front stays ready until it holds an item; the store sweep after
  // reset also holds off new items.
  assign busy_o = !front_ready || clearing;

  tmbc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i && !clearing),
    .ready_o       (front_ready),
    .action_i      (action_i),
    .tile_index_i  (tile_index_i),
    .tile_blocked_i(tile_blocked_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .prev_x_i      (prev_x_i),
    .prev_y_i      (prev_y_i),
    .box_width_i   (box_width_i),
    .box_height_i  (box_height_i),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .cfg_i         (cfg_q),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  tmbc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .pop_i  (pop),
    .data_o (head_entry),
    .full_o (full),
    .empty_o(empty)
  );

  tmbc_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (empty),
    .head_i    (head_entry),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .new_x_o   (new_x),
    .new_y_o   (new_y),
    .outcome_o (outcome)
  );

  assign new_x_o   = new_x;
  assign new_y_o   = new_y;
  assign outcome_o = 2'(outcome);

endmodule

// File: design/tmbc_checker.sv
// Port-level checks for the tile map box collision resolver, bound to the top
// level. Depends on the top level's port list only.

module tmbc_props (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // An accepted item always leaves the block busy in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting an item");

  // The back part passes through its idle state after every result, so results
  // are never shown in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results in two consecutive cycles");

  // The store sweep holds off items right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> busy_o)
    else $error("block not busy while the store is swept after reset");

  // No result can appear in the first cycle out of reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o)
    else $error("result shown right after reset");

endmodule

bind tile_map_box_collision_resolve tmbc_props u_tmbc_checker (.*);

// File: bench/tmbc_checker.sv
// Result checker for the tile map box collision resolver: tracks configuration
// writes and item transfers, predicts each resolve and compares it with done_o.
// Depends on tmbc_pkg for widths and codes.

module tmbc_checker import tmbc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [TILE_W-1:0]         cfg_data_i,
  input  logic                      start_i,
  input  logic                      busy_o,
  input  logic                      action_i,
  input  logic [IDX_W-1:0]          tile_index_i,
  input  logic                      tile_blocked_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] prev_x_i,
  input  logic signed [COORD_W-1:0] prev_y_i,
  input  logic [SIZE_W-1:0]         box_width_i,
  input  logic [SIZE_W-1:0]         box_height_i,
  input  logic signed [OFF_W-1:0]   offset_x_i,
  input  logic signed [OFF_W-1:0]   offset_y_i,
  input  logic                      done_o,
  input  logic signed [COORD_W-1:0] new_x_o,
  input  logic signed [COORD_W-1:0] new_y_o,
  input  logic [1:0]                outcome_o,
  output int                        pending_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS;

  typedef struct {
    coord_t   x;
    coord_t   y;
    outcome_e kind;
  } resolved_t;

  bit                tile_mark [DEPTH];
  cfg_t              cfg;
  resolved_t         resolved_q [$];

  function automatic bit box_blocked(longint cx, longint cy, longint w, longint h);
    longint tw, th, cols, rows, c0, c1, r0, r1, idx;
    tw   = (cfg.tile_width  == 0 ? 1 : longint'(cfg.tile_width)) * 16;
    th   = (cfg.tile_height == 0 ? 1 : longint'(cfg.tile_height)) * 16;
    cols = cfg.map_cols > DEF_MAX_COLS ? DEF_MAX_COLS : longint'(cfg.map_cols);
    rows = cfg.map_rows > DEF_MAX_ROWS ? DEF_MAX_ROWS : longint'(cfg.map_rows);
    // Signed division truncates toward zero, as the tile span requires.
    c0 = cx / tw;
    c1 = (cx + (w - 1) * 16) / tw;
    r0 = cy / th;
    r1 = (cy + (h - 1) * 16) / th;
    for (longint r = r0; r <= r1; r++) begin
      for (longint c = c0; c <= c1; c++) begin
        if (r < 0 || r >= rows || c < 0 || c >= cols) return 1'b1;
        idx = r * cols + c;
        if (idx >= 0 && idx < DEPTH && tile_mark[idx]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic resolved_t resolve_box();
    resolved_t res;
    longint    px, py, qx, qy, w, h, ox, oy, hx, hy;
    px = pos_x_i;  py = pos_y_i;
    qx = prev_x_i; qy = prev_y_i;
    w  = box_width_i; h = box_height_i;
    ox = offset_x_i; oy = offset_y_i;
    hx = px - w * 8 + ox;
    hy = py - h * 8 + oy;
    res.x    = pos_x_i;
    res.y    = pos_y_i;
    res.kind = OUT_FREE;
    if (box_blocked(hx, hy, w, h)) begin
      if (!box_blocked(hx, qy - h * 8 + oy, w, h)) begin
        res.y    = prev_y_i;
        res.kind = OUT_Y;
      end else begin
        res.x = prev_x_i;
        if (!box_blocked(qx - w * 8 + ox, hy, w, h)) begin
          res.kind = OUT_X;
        end else begin
          res.y    = prev_y_i;
          res.kind = OUT_BOTH;
        end
      end
    end
    return res;
  endfunction

  assign pending_o = resolved_q.size();

  always @(posedge clk_i or negedge rst_ni) begin : track
    resolved_t want;
    int        errs;
    if (!rst_ni) begin
      foreach (tile_mark[i]) tile_mark[i] = 1'b0;
      cfg.tile_width  <= RST_TILE_WIDTH;
      cfg.tile_height <= RST_TILE_HEIGHT;
      cfg.map_cols    <= RST_MAP_COLS;
      cfg.map_rows    <= RST_MAP_ROWS;
      fail_count_o    <= 0;
    end else begin
      errs = 0;
      // Results leave before new transfers are predicted, which keeps order.
      if (done_o) begin
        if (resolved_q.size() == 0) begin
          $error("result with no resolve waiting");
          errs++;
        end else begin
          want = resolved_q.pop_front();
          if (new_x_o !== want.x) begin
            $error("new_x expected %0d got %0d", want.x, new_x_o);
            errs++;
          end
          if (new_y_o !== want.y) begin
            $error("new_y expected %0d got %0d", want.y, new_y_o);
            errs++;
          end
          if (outcome_o !== want.kind) begin
            $error("outcome expected %0d got %0d", want.kind, outcome_o);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (start_i && !busy_o) begin
        if (action_i == ACT_WRITE) begin
          if (tile_index_i < DEPTH) tile_mark[tile_index_i] = tile_blocked_i;
        end else begin
          resolved_q.push_back(resolve_box());
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_TILE_WIDTH:  cfg.tile_width  <= cfg_data_i;
          CFG_TILE_HEIGHT: cfg.tile_height <= cfg_data_i;
          CFG_MAP_COLS:    cfg.map_cols    <= cfg_data_i[MAP_W-1:0];
          CFG_MAP_ROWS:    cfg.map_rows    <= cfg_data_i[MAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: bench/tile_map_box_collision_resolve_tb.sv
// Testbench top for the tile map box collision resolver: clock, reset,
// configuration phases and item stimulus. Depends on tmbc_pkg, tmbc_checker
// and the block itself.

module tile_map_box_collision_resolve_tb;
  import tmbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer and no result before the run is called hung. The
  // slowest legal gap is the post-reset clear sweep plus a resolve whose
  // boxes cover the whole map, so this leaves ample margin.
  localparam int STALL_LIMIT    = 300000;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 117;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [TILE_W-1:0] cfg_data_i;
  logic start_i, busy_o;
  logic action_i;
  logic [IDX_W-1:0] tile_index_i;
  logic tile_blocked_i;
  logic signed [COORD_W-1:0] pos_x_i, pos_y_i, prev_x_i, prev_y_i;
  logic [SIZE_W-1:0] box_width_i, box_height_i;
  logic signed [OFF_W-1:0] offset_x_i, offset_y_i;
  logic done_o;
  logic signed [COORD_W-1:0] new_x_o, new_y_o;
  logic [1:0] outcome_o;
  int pending, fail_count;
  int stall_cycles;
  int idle_pct;

  // Effective geometry of the current phase, used to aim boxes at the map.
  int eff_tw, eff_th, eff_cols, eff_rows;

  tile_map_box_collision_resolve u_top (.*);

  tmbc_checker u_checker (
    .pending_o(pending), .fail_count_o(fail_count), .*
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input is known from time zero.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    start_i = 1'b0; action_i = ACT_WRITE; tile_index_i = '0; tile_blocked_i = 1'b0;
    pos_x_i = '0; pos_y_i = '0; prev_x_i = '0; prev_y_i = '0;
    box_width_i = 8'd1; box_height_i = 8'd1; offset_x_i = '0; offset_y_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: counts cycles in which nothing moves in either direction.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    stall_cycles = 0;
    wait (stall_cycles >= STALL_LIMIT);
    $display("[tile_map_box_collision_resolve] ERROR");
    $finish;
  end

  // Writes all four registers back to back; the enable stays high throughout.
  task automatic write_config(logic [7:0] tw, logic [7:0] th, logic [7:0] cols,
                              logic [7:0] rows);
    logic [7:0] vals [4];
    vals = '{tw, th, cols, rows};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    eff_tw   = tw == 0 ? 1 : tw;
    eff_th   = th == 0 ? 1 : th;
    eff_cols = cols[6:0] > DEF_MAX_COLS ? DEF_MAX_COLS : cols[6:0];
    eff_rows = rows[6:0] > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows[6:0];
  endtask

  // One transfer on the start channel, followed by an optional random gap.
  task automatic send_item(logic act, logic [IDX_W-1:0] idx, logic blk,
                           int px, int py, int qx, int qy, int w, int h,
                           int ox, int oy);
    start_i <= 1'b1;
    action_i <= act; tile_index_i <= idx; tile_blocked_i <= blk;
    pos_x_i <= COORD_W'(px); pos_y_i <= COORD_W'(py);
    prev_x_i <= COORD_W'(qx); prev_y_i <= COORD_W'(qy);
    box_width_i <= SIZE_W'(w); box_height_i <= SIZE_W'(h);
    offset_x_i <= OFF_W'(ox); offset_y_i <= OFF_W'(oy);
    do @(posedge clk_i); while (busy_o);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Waits until no result is outstanding and trailing tile writes have drained.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // A Q.4 coordinate that lands somewhere around the map, a little outside too.
  function automatic int map_coord(int tile, int count);
    int span;
    span = tile * 16 * (count + 2);
    return $urandom_range(span) - tile * 16;
  endfunction

  task automatic random_item();
    int px, py, w, h, ox, oy, col, row;
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) begin
      // Tile write inside the used part of the map, mostly open.
      col = eff_cols > 0 ? $urandom_range(eff_cols - 1) : 0;
      row = eff_rows > 0 ? $urandom_range(eff_rows - 1) : 0;
      send_item(ACT_WRITE, IDX_W'(row * eff_cols + col), $urandom_range(99) < 30,
                0, 0, 0, 0, 1, 1, 0, 0);
    end else if (roll < 42) begin
      // Noise: any tile index and any field bits.
      send_item(ACT_WRITE, IDX_W'($urandom), 1'($urandom), $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (roll < 50) begin
      // Noise resolve: every field drawn over its full width.
      send_item(ACT_RESOLVE, IDX_W'($urandom), 1'($urandom), $urandom, $urandom,
                $urandom, $urandom, $urandom_range(255), $urandom_range(255),
                $urandom, $urandom);
    end else begin
      // Boxes of a few tiles near the map, with a small step from the previous
      // position so that the revert paths are exercised.
      w  = $urandom_range(1, eff_tw * 2 > 255 ? 255 : eff_tw * 2);
      h  = $urandom_range(1, eff_th * 2 > 255 ? 255 : eff_th * 2);
      px = map_coord(eff_tw, eff_cols);
      py = map_coord(eff_th, eff_rows);
      ox = $urandom_range(3) == 0 ? int'($urandom_range(64)) - 32 : 0;
      oy = $urandom_range(3) == 0 ? int'($urandom_range(64)) - 32 : 0;
      send_item(ACT_RESOLVE, IDX_W'($urandom), 1'($urandom), px, py,
                px + int'($urandom_range(eff_tw * 32)) - eff_tw * 16,
                py + int'($urandom_range(eff_th * 32)) - eff_th * 16,
                w, h, ox, oy);
    end
  endtask

  initial begin
    logic [7:0] cfg_set [PHASES][4];
    int phase_idle [PHASES];
    cfg_set = '{
      '{8'd16,  8'd16,  8'd64,  8'd64},
      '{8'd1,   8'd1,   8'd64,  8'd64},
      '{8'd255, 8'd255, 8'd1,   8'd1},
      '{8'd0,   8'd0,   8'd10,  8'd7},
      '{8'd8,   8'd24,  8'hFF,  8'd100},
      '{8'd5,   8'd3,   8'd0,   8'd20},
      '{8'd32,  8'd9,   8'd64,  8'd0},
      '{8'd4,   8'd12,  8'd33,  8'd50}
    };
    phase_idle = '{0, 77, 0, 37, 77, 0, 37, 77};
    idle_pct = 0;
    eff_tw = 16; eff_th = 16; eff_cols = 64; eff_rows = 64;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    // Registers are taken while the store is still being swept clear.
    write_config(8'd16, 8'd16, 8'd64, 8'd64);

    // Directed items: store corners, field extremes, a box of zero size, and a
    // corner just above and left of zero that still maps to tile zero.
    send_item(ACT_WRITE, 12'd0, 1'b1, 0, 0, 0, 0, 1, 1, 0, 0);
    send_item(ACT_WRITE, 12'd4095, 1'b1, 0, 0, 0, 0, 1, 1, 0, 0);
    send_item(ACT_RESOLVE, '0, 1'b0, 24, 24, 24, 24, 1, 1, -16, -16);
    send_item(ACT_RESOLVE, '0, 1'b0, 8, 8, 8, 8, 1, 1, -1, -1);
    send_item(ACT_RESOLVE, '0, 1'b0, 300, 300, 300, 300, 0, 0, 0, 0);
    send_item(ACT_RESOLVE, '0, 1'b0, 300, 300, 300, 300, 0, 4, 0, 0);
    send_item(ACT_RESOLVE, '0, 1'b0, 524287, -524288, 524287, -524288, 255, 255,
              32767, -32768);
    send_item(ACT_RESOLVE, '0, 1'b0, -524288, 524287, 1000, 1000, 255, 1, -32768,
              32767);
    send_item(ACT_WRITE, 12'd65, 1'b1, 0, 0, 0, 0, 1, 1, 0, 0);
    // Center of tile (1,1) is blocked; the previous y lies in tile row 2.
    send_item(ACT_RESOLVE, '0, 1'b0, 24*16, 24*16, 24*16, 40*16, 4, 4, 0, 0);
    // Previous x only clears it.
    send_item(ACT_RESOLVE, '0, 1'b0, 24*16, 24*16, 40*16, 24*16, 4, 4, 0, 0);
    // Previous position also blocked on both axes.
    send_item(ACT_RESOLVE, '0, 1'b0, 24*16, 24*16, 24*16 + 1, 24*16 + 2, 4, 4, 0, 0);
    send_item(ACT_RESOLVE, '0, 1'b0, 200*16, 200*16, 201*16, 199*16, 8, 8, 0, 0);
    send_item(ACT_WRITE, 12'd65, 1'b0, 0, 0, 0, 0, 1, 1, 0, 0);
    send_item(ACT_WRITE, 12'd0, 1'b0, 0, 0, 0, 0, 1, 1, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_config(cfg_set[p][0], cfg_set[p][1], cfg_set[p][2], cfg_set[p][3]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Once, hold the sender back until every outstanding result has come.
        if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
          start_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        random_item();
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[tile_map_box_collision_resolve] OK");
    end else begin
      $display("[tile_map_box_collision_resolve] ERROR");
    end
    $finish;
  end

endmodule
